/* rtl/fpe_pkg.sv */
// ----------------------------------------------------------------------------
// fpe_pkg
// shared types, character codes and helper functions of the filename escaper
// ----------------------------------------------------------------------------
package fpe_pkg;

   localparam int MAX_CHAR_BITS = 32;

   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CTRL_MAX = 8'd31;
   localparam logic [7:0] NIB_MASK = 8'h0F;

   localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

   localparam int STEM_MAX  = 4;
   localparam int NUM_SLOTS = 7;
   localparam int TOK_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   typedef struct packed {
      logic esc;
      logic last;
   } tok_ctl_type;

   function automatic logic needs_escape(logic [MAX_CHAR_BITS-1:0] c);
      logic r;
      r = (c <= MAX_CHAR_BITS'(CTRL_MAX)) ||
          c == MAX_CHAR_BITS'("<") || c == MAX_CHAR_BITS'(">") ||
          c == MAX_CHAR_BITS'(":") || c == MAX_CHAR_BITS'("\"") ||
          c == MAX_CHAR_BITS'("/") || c == MAX_CHAR_BITS'("\\") ||
          c == MAX_CHAR_BITS'("|") || c == MAX_CHAR_BITS'("?") ||
          c == MAX_CHAR_BITS'("*");
      return r;
   endfunction

   function automatic logic [7:0] hex_digit(logic [3:0] n);
      logic [7:0] d;
      d = HEX_DIGITS[8*(15 - int'(n)) +: 8];
      return d;
   endfunction

   function automatic logic is_device(logic [MAX_CHAR_BITS-1:0] s0,
                                      logic [MAX_CHAR_BITS-1:0] s1,
                                      logic [MAX_CHAR_BITS-1:0] s2,
                                      logic [MAX_CHAR_BITS-1:0] s3,
                                      logic [2:0] len);
      logic three;
      logic four;
      three = (s0 == MAX_CHAR_BITS'("C") && s1 == MAX_CHAR_BITS'("O") &&
               s2 == MAX_CHAR_BITS'("N")) ||
              (s0 == MAX_CHAR_BITS'("P") && s1 == MAX_CHAR_BITS'("R") &&
               s2 == MAX_CHAR_BITS'("N")) ||
              (s0 == MAX_CHAR_BITS'("A") && s1 == MAX_CHAR_BITS'("U") &&
               s2 == MAX_CHAR_BITS'("X")) ||
              (s0 == MAX_CHAR_BITS'("N") && s1 == MAX_CHAR_BITS'("U") &&
               s2 == MAX_CHAR_BITS'("L"));
      four  = ((s0 == MAX_CHAR_BITS'("C") && s1 == MAX_CHAR_BITS'("O") &&
                s2 == MAX_CHAR_BITS'("M")) ||
               (s0 == MAX_CHAR_BITS'("L") && s1 == MAX_CHAR_BITS'("P") &&
                s2 == MAX_CHAR_BITS'("T"))) &&
              s3 >= MAX_CHAR_BITS'("1") && s3 <= MAX_CHAR_BITS'("9");
      return (len == 3'd3 && three) || (len == 3'd4 && four);
   endfunction

endpackage

/* rtl/filename_percent_escaper.sv */
// ----------------------------------------------------------------------------
// filename_percent_escaper
// escapes a file name stream for windows-style file systems
//
//   channel   direction  handshake            payload
//   req       in         req_push / req_full   req_char, req_last
//   rsp       out        rsp_pop / rsp_empty   rsp_char, rsp_last
//
// one request per cycle is taken while the token queue has room
// each result is one character on rsp; an escaped character becomes three
// a request that ends the stem holds req_full while the front
// issues the held stem tokens
// reset is synchronous and clears all control state
// a stalled rsp_pop backs up through the queues to req_full
// ----------------------------------------------------------------------------
module filename_percent_escaper #(
   parameter int CHAR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CHAR_BITS-1:0] req_char,
   input  logic                 req_last,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CHAR_BITS-1:0] rsp_char,
   output logic                 rsp_last
);

   localparam int TW = CHAR_BITS + $bits(fpe_pkg::tok_ctl_type);
   localparam int OW = CHAR_BITS + 1;

   logic                 ft_push, ft_full;
   logic [CHAR_BITS-1:0] ft_char;
   fpe_pkg::tok_ctl_type ft_ctl;

   logic                 bt_empty, bt_pop;
   logic [CHAR_BITS-1:0] bt_char;
   fpe_pkg::tok_ctl_type bt_ctl;

   logic                 bo_push, bo_full;
   logic [CHAR_BITS-1:0] bo_char;
   logic                 bo_last;

   fpe_front #(.CHAR_BITS(CHAR_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_push  (req_push),
      .in_full  (req_full),
      .in_char  (req_char),
      .in_last  (req_last),
      .tok_push (ft_push),
      .tok_full (ft_full),
      .tok_char (ft_char),
      .tok_ctl  (ft_ctl)
   );

   fpe_fifo #(.WIDTH(TW), .DEPTH(fpe_pkg::TOK_DEPTH)) u_tok_q (
      .clock (clock),
      .reset (reset),
      .push  (ft_push),
      .full  (ft_full),
      .din   ({ft_ctl, ft_char}),
      .pop   (bt_pop),
      .empty (bt_empty),
      .dout  ({bt_ctl, bt_char})
   );

   fpe_back #(.CHAR_BITS(CHAR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (bt_empty),
      .tok_pop   (bt_pop),
      .tok_char  (bt_char),
      .tok_ctl   (bt_ctl),
      .out_push  (bo_push),
      .out_full  (bo_full),
      .out_char  (bo_char),
      .out_last  (bo_last)
   );

   fpe_fifo #(.WIDTH(OW), .DEPTH(fpe_pkg::OUT_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (bo_push),
      .full  (bo_full),
      .din   ({bo_last, bo_char}),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  ({rsp_last, rsp_char})
   );

endmodule

/* rtl/fpe_fifo.sv */
// ----------------------------------------------------------------------------
// fpe_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module fpe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign dout    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

/* rtl/fpe_front.sv */
// ----------------------------------------------------------------------------
// fpe_front
// holds the stem, decides the device-name prefix and issues one token a cycle while the token queue has room
// ----------------------------------------------------------------------------
module fpe_front #(
   parameter int CHAR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_push,
   output logic                 in_full,
   input  logic [CHAR_BITS-1:0] in_char,
   input  logic                 in_last,
   output logic                 tok_push,
   input  logic                 tok_full,
   output logic [CHAR_BITS-1:0] tok_char,
   output fpe_pkg::tok_ctl_type tok_ctl
);

   localparam int NS = fpe_pkg::NUM_SLOTS;
   localparam int SM = fpe_pkg::STEM_MAX;
   localparam int MW = fpe_pkg::MAX_CHAR_BITS;

   logic [CHAR_BITS-1:0] buf_ff [SM];
   logic [CHAR_BITS-1:0] buf_in [SM];
   logic [CHAR_BITS-1:0] cur_ff, cur_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 decided_ff, decided_in;
   logic [NS-1:0]        slot_ff, slot_in;
   logic                 plast_ff, plast_in;

   logic [NS-1:0]        sel;
   logic [NS-1:0]        slot_left;
   logic                 found;
   logic                 emit;
   logic                 acc;
   logic                 is_dot;
   logic                 trail;
   logic                 cur_in_stem;
   logic [2:0]           len;
   logic                 match;
   logic [CHAR_BITS-1:0] st [SM];

   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = 0; i < NS; i++) begin
         if (slot_ff[i] && !found) begin
            sel[i] = 1'b1;
            found  = 1'b1;
         end
      end
   end

   always_comb begin
      tok_char = cur_ff;
      if (sel[0] || sel[NS-1]) begin
         tok_char = CHAR_BITS'(fpe_pkg::CH_HASH);
      end
      for (int i = 0; i < SM; i++) begin
         if (sel[i+1]) begin
            tok_char = buf_ff[i];
         end
      end
   end

   assign emit          = (|slot_ff) && !tok_full;
   assign tok_push      = |slot_ff;
   assign slot_left     = emit ? (slot_ff & ~sel) : slot_ff;
   assign tok_ctl.esc   = fpe_pkg::needs_escape(MW'(tok_char));
   assign tok_ctl.last  = plast_ff && ((slot_ff & ~sel) == '0);
   assign in_full       = (slot_left != '0);
   assign acc           = in_push && !in_full;

   assign is_dot      = (in_char == CHAR_BITS'(fpe_pkg::CH_DOT));
   assign trail       = in_last && (is_dot || in_char == CHAR_BITS'(fpe_pkg::CH_SPACE));
   assign cur_in_stem = !is_dot && (cnt_ff < 3'(SM));
   assign len         = cnt_ff + {2'b00, cur_in_stem};

   always_comb begin
      for (int i = 0; i < SM; i++) begin
         st[i] = (3'(i) < cnt_ff) ? buf_ff[i] : in_char;
      end
   end

   assign match = (is_dot || cur_in_stem) &&
                  fpe_pkg::is_device(MW'(st[0]), MW'(st[1]), MW'(st[2]), MW'(st[3]), len);

   always_comb begin
      buf_in     = buf_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      decided_in = decided_ff;
      slot_in    = slot_left;
      plast_in   = plast_ff;
      if (acc) begin
         cur_in   = in_char;
         plast_in = in_last;
         if (!decided_ff) begin
            if (!is_dot && !in_last && cnt_ff < 3'(SM)) begin
               buf_in[cnt_ff[1:0]] = in_char;
               cnt_in              = cnt_ff + 3'd1;
            end else begin
               slot_in[0]    = match;
               for (int i = 0; i < SM; i++) begin
                  slot_in[i+1] = (3'(i) < cnt_ff);
               end
               slot_in[NS-2] = 1'b1;
               slot_in[NS-1] = trail;
               decided_in    = 1'b1;
            end
         end else begin
            slot_in[NS-2] = 1'b1;
            slot_in[NS-1] = trail;
         end
         if (in_last) begin
            cnt_in     = 3'd0;
            decided_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 3'd0;
         decided_ff <= 1'b0;
         slot_ff    <= '0;
         plast_ff   <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         decided_ff <= decided_in;
         slot_ff    <= slot_in;
         plast_ff   <= plast_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      cur_ff <= cur_in;
   end

endmodule

/* rtl/fpe_back.sv */
// ----------------------------------------------------------------------------
// fpe_back
// expands each token into one character or a percent escape of three
// ----------------------------------------------------------------------------
module fpe_back #(
   parameter int CHAR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_empty,
   output logic                 tok_pop,
   input  logic [CHAR_BITS-1:0] tok_char,
   input  fpe_pkg::tok_ctl_type tok_ctl,
   output logic                 out_push,
   input  logic                 out_full,
   output logic [CHAR_BITS-1:0] out_char,
   output logic                 out_last
);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_HIGH,
      PH_LOW
   } phase_type;

   phase_type ph_ff, ph_in;
   logic      go;

   assign go       = !tok_empty && !out_full;
   assign out_push = go;
   assign tok_pop  = go && (ph_ff == PH_LOW || !tok_ctl.esc);

   always_comb begin
      case (ph_ff)
         PH_FIRST: begin
            out_char = tok_ctl.esc ? CHAR_BITS'(fpe_pkg::CH_PCT) : tok_char;
            out_last = !tok_ctl.esc && tok_ctl.last;
         end
         PH_HIGH: begin
            out_char = CHAR_BITS'(fpe_pkg::hex_digit(tok_char[7:4]));
            out_last = 1'b0;
         end
         PH_LOW: begin
            out_char = CHAR_BITS'(fpe_pkg::hex_digit(tok_char[3:0]));
            out_last = tok_ctl.last;
         end
         default: begin
            out_char = tok_char;
            out_last = tok_ctl.last;
         end
      endcase
   end

   always_comb begin
      ph_in = ph_ff;
      if (go) begin
         if (tok_pop) begin
            ph_in = PH_FIRST;
         end else if (ph_ff == PH_FIRST) begin
            ph_in = PH_HIGH;
         end else begin
            ph_in = PH_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_FIRST;
      end else begin
         ph_ff <= ph_in;
      end
   end

endmodule

/* rtl/fpe_checker.sv */
// ----------------------------------------------------------------------------
// fpe_checker
// port-level checks of the filename escaper, bound to the top level
// ----------------------------------------------------------------------------
module fpe_checker #(
   parameter int CHAR_BITS = 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [CHAR_BITS-1:0] rsp_char,
   input logic                 rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_char) && $stable(rsp_last)))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("rsp not empty after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("req full after reset");

   a_no_raw_reserved: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_char <= CHAR_BITS'(31) ||
                       rsp_char == CHAR_BITS'("<") || rsp_char == CHAR_BITS'(">") ||
                       rsp_char == CHAR_BITS'(":") || rsp_char == CHAR_BITS'("\"") ||
                       rsp_char == CHAR_BITS'("/") || rsp_char == CHAR_BITS'("\\") ||
                       rsp_char == CHAR_BITS'("|") || rsp_char == CHAR_BITS'("?") ||
                       rsp_char == CHAR_BITS'("*")))
      else $error("unescaped reserved character on rsp");

endmodule

bind filename_percent_escaper fpe_checker #(.CHAR_BITS(CHAR_BITS)) u_fpe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_char  (rsp_char),
   .rsp_last  (rsp_last)
);
